/* src/tspcr_pkg.sv */
`timescale 1ns / 1ps
// Package for the transport-stream PCR bitrate estimator.
// Holds header constants, result codes and datapath widths; no dependencies.
package tspcr_pkg;

    // Packet header decoding
    localparam logic [7:0]  TS_SYNC       = 8'h47;
    localparam logic [7:0]  PCR_FLAG      = 8'h10;
    localparam logic [7:0]  MIN_ADAPT_LEN = 8'd7;
    localparam logic [15:0] PID_MASK      = 16'h1fff;
    localparam logic [47:0] PCR_EXT_MASK  = 48'h0000_0000_01ff;

    // PCR base ticks (90 kHz) to 27 MHz ticks, and bits in one 188-byte packet
    localparam int PCR_EXT_SCALE      = 300;
    localparam int TS_BITS_PER_PACKET = 188 * 8;

    // Datapath widths
    localparam int PID_W   = 13;
    localparam int PCR_W   = 42;
    localparam int CLK_W   = 27;
    localparam int A_W     = 38;          // pcr_clock_hz * 1504
    localparam int ALU_W   = PCR_W + 1;   // shared add/subtract unit
    localparam int RATE_W  = 48;
    localparam int SLIM_W  = 10;
    localparam int DEFR_W  = 32;

    // Reset values of the configuration registers
    localparam logic [DEFR_W-1:0] DEFAULT_BITRATE_RST = 32'd26970350;
    localparam logic [SLIM_W-1:0] SEARCH_LIMIT_RST    = 10'd100;
    localparam logic [CLK_W-1:0]  PCR_CLOCK_HZ_RST    = 27'd27000000;

    // Request kinds on the input side
    typedef enum logic [1:0] {
        REQ_HEADER    = 2'd0,
        REQ_END       = 2'd1,
        REQ_TRUNCATED = 2'd2,
        REQ_UNKNOWN   = 2'd3
    } req_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_MEASURED   = 2'd0,
        ST_DEFAULT    = 2'd1,
        ST_NOT_STREAM = 2'd2,
        ST_ZERO_RATE  = 2'd3
    } status_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEFAULT_BITRATE = 2'd0;
    localparam logic [1:0] CFG_SEARCH_LIMIT    = 2'd1;
    localparam logic [1:0] CFG_PCR_CLOCK_HZ    = 2'd2;

endpackage

/* src/ts_pcr_bitrate_estimator.sv */
`timescale 1ns / 1ps
// Transport-stream PCR bitrate estimator, top level.
// Depends on tspcr_pkg for constants, widths and codes.
//
// The block takes one packet header per transfer and looks for two PCRs on
// the same PID; from the pair it reports pcr_clock_hz * 1504 * packets /
// PCR increase, saturated to 48 bits, and then restarts its search. End of
// stream or hitting search_limit reports default_bitrate, a truncated packet
// or a PCR that does not advance reports "not a stream", and a zero quotient
// reports an error. Only one item is in work at a time: s_tready is high
// while the sequencer is idle. A plain header passes through S_DECODE back
// to S_IDLE; a PCR that opens a pair or sits on another PID also passes
// through S_PCR, a request that is decided at once through S_EMIT, and a PCR
// that does not advance through S_PCR, S_DELTA and S_EMIT. For the closing
// PCR of a pair, one shared 43-bit add/subtract unit runs a shift-add multiply
// (COUNT_WIDTH steps) followed by a restoring divide (38 + COUNT_WIDTH
// steps), one bit per cycle. A finished result sits in an output register,
// so the next header is taken while it waits for m_tready; a further result
// holds the sequencer until that register is free. Configuration writes are
// always accepted; write them only while the block is idle.
module ts_pcr_bitrate_estimator
    import tspcr_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] sync_byte, [23:8] pid_bytes, [31:24] control_byte,
    // [39:32] adapt_length, [47:40] adapt_flags, [95:48] pcr_bytes
    input  logic [95:0] s_tdata,
    // [1:0] req_type
    input  logic [1:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [47:0] bitrate, [60:48] pcr_pid, [63:61] zero
    output logic [63:0] m_tdata,
    // [1:0] status
    output logic [1:0]  m_tuser,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int PW    = A_W + COUNT_WIDTH;   // product / quotient width
    localparam int CNT_W = $clog2(PW);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_PCR,
        S_DELTA,
        S_MUL,
        S_DIV,
        S_FINISH,
        S_EMIT
    } state_t;

    state_t state_reg;

    // Configuration
    logic [DEFR_W-1:0] default_bitrate_reg;
    logic [SLIM_W-1:0] search_limit_reg;
    logic [CLK_W-1:0]  pcr_clock_hz_reg;

    // Captured header
    logic [1:0]  in_req_reg;
    logic [7:0]  in_sync_reg;
    logic [15:0] in_pid_reg;
    logic [7:0]  in_ctrl_reg;
    logic [7:0]  in_alen_reg;
    logic [7:0]  in_flags_reg;
    logic [47:0] in_pcr_reg;

    // Search state
    logic                   phase_reg;
    logic [COUNT_WIDTH-1:0] packet_count_reg;
    logic [COUNT_WIDTH-1:0] first_index_reg;
    logic [PCR_W-1:0]       first_pcr_reg;
    logic [PID_W-1:0]       first_pid_reg;
    logic [SLIM_W-1:0]      search_count_reg;

    // Arithmetic datapath
    logic [PCR_W-1:0] pcr_reg;
    logic [PCR_W-1:0] d_reg;
    logic [A_W-1:0]   mcand_reg;
    logic [PW-1:0]    prod_reg;
    logic [PCR_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;

    // Pending result and output register
    logic [1:0]        res_status_reg;
    logic [RATE_W-1:0] res_rate_reg;
    logic [PID_W-1:0]  res_pid_reg;
    logic              out_valid_reg;
    logic [1:0]        out_status_reg;
    logic [RATE_W-1:0] out_rate_reg;
    logic [PID_W-1:0]  out_pid_reg;

    // Header decode
    logic              has_pcr;
    logic [PID_W-1:0]  in_pid;
    logic [PCR_W-1:0]  pcr_calc;
    logic [SLIM_W-1:0] search_inc;
    logic [A_W-1:0]    a_calc;
    logic [COUNT_WIDTH-1:0] packets;

    assign in_pid  = PID_W'(in_pid_reg & PID_MASK);
    assign has_pcr = (in_sync_reg == TS_SYNC) && in_ctrl_reg[5]
                  && (in_alen_reg >= MIN_ADAPT_LEN)
                  && ((in_flags_reg & PCR_FLAG) != 8'd0);
    // base * 300 + extension, kept to 42 bits
    assign pcr_calc = PCR_W'(in_pcr_reg[47:15]) * PCR_W'(PCR_EXT_SCALE)
                    + PCR_W'(in_pcr_reg & PCR_EXT_MASK);
    assign search_inc = search_count_reg + SLIM_W'(1);
    assign a_calc     = A_W'(pcr_clock_hz_reg) * A_W'(TS_BITS_PER_PACKET);
    assign packets    = packet_count_reg - first_index_reg;

    // Shared add/subtract unit; the top bit is the carry (x >= y when subtracting)
    logic [ALU_W-1:0] alu_x;
    logic [ALU_W-1:0] alu_y;
    logic             alu_sub;
    logic [ALU_W:0]   alu_sum;

    always_comb
    begin
        alu_x   = '0;
        alu_y   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            S_DELTA:
            begin
                alu_x   = {1'b0, pcr_reg};
                alu_y   = {1'b0, first_pcr_reg};
                alu_sub = 1'b1;
            end
            S_MUL:
            begin
                alu_x = ALU_W'(prod_reg[PW-1:COUNT_WIDTH]);
                alu_y = ALU_W'(mcand_reg);
            end
            S_DIV:
            begin
                alu_x   = {rem_reg, prod_reg[PW-1]};
                alu_y   = {1'b0, d_reg};
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_x = '0;
            end
        endcase
    end

    assign alu_sum = {1'b0, alu_x} + {1'b0, (alu_sub ? ~alu_y : alu_y)}
                   + {{ALU_W{1'b0}}, alu_sub};

    logic             alu_ge;
    logic [PCR_W-1:0] alu_diff;
    logic [A_W:0]     mul_upper;
    logic             quo_over;
    logic             quo_zero;
    logic             emit_go;

    assign alu_ge    = alu_sum[ALU_W];
    assign alu_diff  = alu_sum[PCR_W-1:0];
    assign mul_upper = prod_reg[0] ? alu_sum[A_W:0] : {1'b0, prod_reg[PW-1:COUNT_WIDTH]};
    assign quo_over  = |prod_reg[PW-1:RATE_W];
    assign quo_zero  = (prod_reg == '0);
    // The pending result moves into a free or draining output register
    assign emit_go   = (state_reg == S_EMIT) && (!out_valid_reg || m_tready);

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = out_status_reg;
    assign m_tdata   = {3'b000, out_pid_reg, out_rate_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            default_bitrate_reg <= DEFAULT_BITRATE_RST;
            search_limit_reg    <= SEARCH_LIMIT_RST;
            pcr_clock_hz_reg    <= PCR_CLOCK_HZ_RST;
            in_req_reg          <= '0;
            in_sync_reg         <= '0;
            in_pid_reg          <= '0;
            in_ctrl_reg         <= '0;
            in_alen_reg         <= '0;
            in_flags_reg        <= '0;
            in_pcr_reg          <= '0;
            phase_reg           <= 1'b0;
            packet_count_reg    <= '0;
            first_index_reg     <= '0;
            first_pcr_reg       <= '0;
            first_pid_reg       <= '0;
            search_count_reg    <= '0;
            pcr_reg             <= '0;
            d_reg               <= '0;
            mcand_reg           <= '0;
            prod_reg            <= '0;
            rem_reg             <= '0;
            cnt_reg             <= '0;
            res_status_reg      <= '0;
            res_rate_reg        <= '0;
            res_pid_reg         <= '0;
            out_valid_reg       <= 1'b0;
            out_status_reg      <= '0;
            out_rate_reg        <= '0;
            out_pid_reg         <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_DEFAULT_BITRATE: default_bitrate_reg <= cfg_data;
                    CFG_SEARCH_LIMIT:    search_limit_reg    <= cfg_data[SLIM_W-1:0];
                    CFG_PCR_CLOCK_HZ:    pcr_clock_hz_reg    <= cfg_data[CLK_W-1:0];
                    default:             ;
                endcase
            end

            // Drop the output once it has been taken, unless a new one replaces it
            if (out_valid_reg && m_tready && !emit_go)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        in_req_reg   <= s_tuser;
                        in_sync_reg  <= s_tdata[7:0];
                        in_pid_reg   <= s_tdata[23:8];
                        in_ctrl_reg  <= s_tdata[31:24];
                        in_alen_reg  <= s_tdata[39:32];
                        in_flags_reg <= s_tdata[47:40];
                        in_pcr_reg   <= s_tdata[95:48];
                        state_reg    <= S_DECODE;
                    end
                end

                S_DECODE:
                begin
                    case (in_req_reg)
                        REQ_END:
                        begin
                            res_status_reg <= ST_DEFAULT;
                            res_rate_reg   <= RATE_W'(default_bitrate_reg);
                            res_pid_reg    <= '0;
                            state_reg      <= S_EMIT;
                        end
                        REQ_TRUNCATED:
                        begin
                            res_status_reg <= ST_NOT_STREAM;
                            res_rate_reg   <= '0;
                            res_pid_reg    <= '0;
                            state_reg      <= S_EMIT;
                        end
                        REQ_HEADER:
                        begin
                            packet_count_reg <= packet_count_reg + COUNT_WIDTH'(1);
                            if (!has_pcr)
                            begin
                                search_count_reg <= search_inc;
                                if (search_inc >= search_limit_reg)
                                begin
                                    res_status_reg <= ST_DEFAULT;
                                    res_rate_reg   <= RATE_W'(default_bitrate_reg);
                                    res_pid_reg    <= '0;
                                    state_reg      <= S_EMIT;
                                end
                                else
                                begin
                                    state_reg <= S_IDLE;
                                end
                            end
                            else
                            begin
                                search_count_reg <= '0;
                                state_reg        <= S_PCR;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_IDLE;
                        end
                    endcase
                end

                S_PCR:
                begin
                    pcr_reg <= pcr_calc;
                    if (!phase_reg)
                    begin
                        // First PCR: hold it and its position
                        phase_reg       <= 1'b1;
                        first_pcr_reg   <= pcr_calc;
                        first_pid_reg   <= in_pid;
                        first_index_reg <= packet_count_reg;
                        state_reg       <= S_IDLE;
                    end
                    else if (in_pid != first_pid_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_DELTA;
                    end
                end

                S_DELTA:
                begin
                    if (!alu_ge || (alu_diff == '0))
                    begin
                        res_status_reg <= ST_NOT_STREAM;
                        res_rate_reg   <= '0;
                        res_pid_reg    <= '0;
                        state_reg      <= S_EMIT;
                    end
                    else
                    begin
                        d_reg     <= alu_diff;
                        mcand_reg <= a_calc;
                        prod_reg  <= PW'(packets);
                        cnt_reg   <= CNT_W'(COUNT_WIDTH - 1);
                        state_reg <= S_MUL;
                    end
                end

                S_MUL:
                begin
                    // Shift-add multiply, multiplier bits leave at the bottom
                    prod_reg <= {mul_upper, prod_reg[COUNT_WIDTH-1:1]};
                    if (cnt_reg == '0)
                    begin
                        cnt_reg   <= CNT_W'(PW - 1);
                        rem_reg   <= '0;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - CNT_W'(1);
                    end
                end

                S_DIV:
                begin
                    // Restoring divide, quotient bits shift in at the bottom
                    rem_reg  <= alu_ge ? alu_diff : {rem_reg[PCR_W-2:0], prod_reg[PW-1]};
                    prod_reg <= {prod_reg[PW-2:0], alu_ge};
                    if (cnt_reg == '0)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - CNT_W'(1);
                    end
                end

                S_FINISH:
                begin
                    if (quo_zero)
                    begin
                        res_status_reg <= ST_ZERO_RATE;
                        res_rate_reg   <= '0;
                        res_pid_reg    <= '0;
                    end
                    else
                    begin
                        res_status_reg <= ST_MEASURED;
                        res_rate_reg   <= quo_over ? {RATE_W{1'b1}} : prod_reg[RATE_W-1:0];
                        res_pid_reg    <= first_pid_reg;
                    end
                    state_reg <= S_EMIT;
                end

                S_EMIT:
                begin
                    // Advance once the output register is free
                    if (emit_go)
                    begin
                        out_valid_reg    <= 1'b1;
                        out_status_reg   <= res_status_reg;
                        out_rate_reg     <= res_rate_reg;
                        out_pid_reg      <= res_pid_reg;
                        state_reg        <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // Restart the search once a result moves into the output register
            if (emit_go)
            begin
                phase_reg        <= 1'b0;
                packet_count_reg <= '0;
                first_index_reg  <= '0;
                first_pcr_reg    <= '0;
                first_pid_reg    <= '0;
                search_count_reg <= '0;
            end
        end
    end

    // A measured result is never zero
    a_measured_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == ST_MEASURED)) |-> (out_rate_reg != '0))
        else $error("measured bitrate is zero");

    // Only a measured result names a PID
    a_pid_only_measured: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != ST_MEASURED)) |-> (out_pid_reg == '0))
        else $error("non-measured result carries a PID");

    // The divider never runs with a zero divisor
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (d_reg != '0))
        else $error("divide by zero");

    // While searching the first PCR no first-PCR state is held
    a_phase_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !phase_reg |-> ((first_pcr_reg == '0) && (first_pid_reg == '0)
                        && (first_index_reg == '0)))
        else $error("stale first PCR state");

    // A result is loaded only into a free or draining output register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> (out_valid_reg && $stable(out_rate_reg)))
        else $error("pending result overwritten");

endmodule
